// ===== rtl/rshd_pkg.sv =====
// ----------------------------------------------------------------------------
// rshd_pkg: shared constants for the ray / sphere hit distance block
// Fixed widths of the direction and distance fields, the width at which
// the squares are formed without any pre-shift, and the projection rounding.
// ----------------------------------------------------------------------------
package rshd_pkg;

  // direction components, signed Q1.16
  localparam int DIR_WIDTH  = 18;
  // hit distance, signed Q14.12
  localparam int DIST_WIDTH = 27;
  // coordinate width above which operands are shifted before squaring
  localparam int REF_WIDTH  = 24;
  // rounding bias and shift that take the Q.28 dot product to Q.12
  localparam int PROJ_SHIFT = 16;
  localparam int PROJ_ROUND = 32768;

endpackage

// ===== rtl/rshd_front.sv =====
// ----------------------------------------------------------------------------
// rshd_front: geometry stages of the hit distance pipeline
// Five register stages: delta, products and squares, projection, projection
// square, then perpendicular clamp, hit test and the radicand for the root.
// ----------------------------------------------------------------------------
module rshd_front
  import rshd_pkg::*;
#(
  parameter int COORD_WIDTH = 24
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_vld,
  input  logic signed [COORD_WIDTH-1:0] in_origin_x,
  input  logic signed [COORD_WIDTH-1:0] in_origin_y,
  input  logic signed [COORD_WIDTH-1:0] in_origin_z,
  input  logic signed [DIR_WIDTH-1:0]   in_dir_x,
  input  logic signed [DIR_WIDTH-1:0]   in_dir_y,
  input  logic signed [DIR_WIDTH-1:0]   in_dir_z,
  input  logic signed [COORD_WIDTH-1:0] in_center_x,
  input  logic signed [COORD_WIDTH-1:0] in_center_y,
  input  logic signed [COORD_WIDTH-1:0] in_center_z,
  input  logic [COORD_WIDTH-2:0]        in_sphere_radius,
  output logic                          out_vld,
  output logic                          out_hit,
  output logic signed [COORD_WIDTH+5:0] out_proj,
  output logic [2*(COORD_WIDTH-1-((COORD_WIDTH > REF_WIDTH) ?
                 (COORD_WIDTH - REF_WIDTH) : 0))-1:0] out_radicand
);

  localparam int RS    = (COORD_WIDTH > REF_WIDTH) ? (COORD_WIDTH - REF_WIDTH) : 0;
  localparam int DW    = COORD_WIDTH + 1;        // delta
  localparam int PW    = DW + DIR_WIDTH;         // delta * dir
  localparam int DOTW  = PW + 3;                 // dot sum plus rounding bias
  localparam int PROJW = DOTW - PROJ_SHIFT;      // projection, Q.12
  localparam int RW    = DW - RS;                // reduced delta
  localparam int RRW   = COORD_WIDTH - 1 - RS;   // reduced radius
  localparam int PRW   = PROJW - RS;             // reduced projection
  localparam int SQW   = 2 * RW + 2;             // sum of delta squares
  localparam int PPW   = 2 * PRW;                // projection square
  localparam int ESW   = PPW + 1;                // signed perpendicular square
  localparam int DFW   = 2 * RRW;                // radicand

  // stage 1: delta
  logic                 s1_vld_r;
  logic signed [DW-1:0] s1_dx_r, s1_dy_r, s1_dz_r;
  logic signed [DW-1:0] s1_dx_nxt, s1_dy_nxt, s1_dz_nxt;
  logic signed [DIR_WIDTH-1:0] s1_ux_r, s1_uy_r, s1_uz_r;
  logic [COORD_WIDTH-2:0] s1_rad_r;

  // stage 2: products and squares
  logic                 s2_vld_r;
  logic signed [PW-1:0] s2_px_r, s2_py_r, s2_pz_r;
  logic signed [PW-1:0] s2_px_nxt, s2_py_nxt, s2_pz_nxt;
  logic [2*RW-1:0]      s2_sx_r, s2_sy_r, s2_sz_r;
  logic [2*RW-1:0]      s2_sx_nxt, s2_sy_nxt, s2_sz_nxt;
  logic [DFW-1:0]       s2_rsq_r, s2_rsq_nxt;
  logic signed [RW-1:0] dr_x, dr_y, dr_z;
  logic [RRW-1:0]       rr;

  // stage 3: projection and delta square sum
  logic                    s3_vld_r;
  logic signed [DOTW-1:0]  s3_dot;
  logic signed [PROJW-1:0] s3_proj_r, s3_proj_nxt;
  logic [SQW-1:0]          s3_dsq_r, s3_dsq_nxt;
  logic [DFW-1:0]          s3_rsq_r;

  // stage 4: projection square
  logic                    s4_vld_r;
  logic signed [PRW-1:0]   pr;
  logic [PPW-1:0]          s4_pp_r, s4_pp_nxt;
  logic signed [PROJW-1:0] s4_proj_r;
  logic [SQW-1:0]          s4_dsq_r;
  logic [DFW-1:0]          s4_rsq_r;

  // stage 5: clamp, hit test, radicand
  logic                    s5_vld_r, s5_hit_r, s5_hit_nxt;
  logic signed [ESW-1:0]   dist_sqr;
  logic [PPW-1:0]          dist_clamp;
  logic [DFW-1:0]          s5_rad_r, s5_rad_nxt;
  logic signed [PROJW-1:0] s5_proj_r;

  // form the delta from origin to centre
  always_comb begin
    s1_dx_nxt = DW'(in_center_x) - DW'(in_origin_x);
    s1_dy_nxt = DW'(in_center_y) - DW'(in_origin_y);
    s1_dz_nxt = DW'(in_center_z) - DW'(in_origin_z);
  end

  // multiply delta by direction; square the reduced delta and radius
  always_comb begin
    dr_x      = RW'(s1_dx_r >>> RS);
    dr_y      = RW'(s1_dy_r >>> RS);
    dr_z      = RW'(s1_dz_r >>> RS);
    rr        = RRW'(s1_rad_r >> RS);
    s2_px_nxt = PW'(s1_dx_r) * PW'(s1_ux_r);
    s2_py_nxt = PW'(s1_dy_r) * PW'(s1_uy_r);
    s2_pz_nxt = PW'(s1_dz_r) * PW'(s1_uz_r);
    s2_sx_nxt = (2*RW)'(dr_x * dr_x);
    s2_sy_nxt = (2*RW)'(dr_y * dr_y);
    s2_sz_nxt = (2*RW)'(dr_z * dr_z);
    s2_rsq_nxt = DFW'(rr) * DFW'(rr);
  end

  // sum the dot product, round to Q.12; sum the delta squares
  always_comb begin
    s3_dot      = DOTW'(s2_px_r) + DOTW'(s2_py_r) + DOTW'(s2_pz_r) + DOTW'(PROJ_ROUND);
    s3_proj_nxt = PROJW'(s3_dot >>> PROJ_SHIFT);
    s3_dsq_nxt  = SQW'(s2_sx_r) + SQW'(s2_sy_r) + SQW'(s2_sz_r);
  end

  // square the reduced projection
  always_comb begin
    pr        = PRW'(s3_proj_r >>> RS);
    s4_pp_nxt = PPW'(pr * pr);
  end

  // clamp the perpendicular square at zero, test against the radius square
  always_comb begin
    dist_sqr   = $signed(ESW'(s4_dsq_r)) - $signed(ESW'(s4_pp_r));
    dist_clamp = dist_sqr[ESW-1] ? '0 : PPW'(dist_sqr);
    s5_hit_nxt = (dist_clamp <= PPW'(s4_rsq_r));
    s5_rad_nxt = s5_hit_nxt ? DFW'(PPW'(s4_rsq_r) - dist_clamp) : '0;
  end

  // advance the valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
      s5_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= in_vld;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
      s4_vld_r <= s3_vld_r;
      s5_vld_r <= s4_vld_r;
    end
  end

  // advance the payload
  always_ff @(posedge clk) begin
    s1_dx_r   <= s1_dx_nxt;
    s1_dy_r   <= s1_dy_nxt;
    s1_dz_r   <= s1_dz_nxt;
    s1_ux_r   <= in_dir_x;
    s1_uy_r   <= in_dir_y;
    s1_uz_r   <= in_dir_z;
    s1_rad_r  <= in_sphere_radius;
    s2_px_r   <= s2_px_nxt;
    s2_py_r   <= s2_py_nxt;
    s2_pz_r   <= s2_pz_nxt;
    s2_sx_r   <= s2_sx_nxt;
    s2_sy_r   <= s2_sy_nxt;
    s2_sz_r   <= s2_sz_nxt;
    s2_rsq_r  <= s2_rsq_nxt;
    s3_proj_r <= s3_proj_nxt;
    s3_dsq_r  <= s3_dsq_nxt;
    s3_rsq_r  <= s2_rsq_r;
    s4_pp_r   <= s4_pp_nxt;
    s4_proj_r <= s3_proj_r;
    s4_dsq_r  <= s3_dsq_r;
    s4_rsq_r  <= s3_rsq_r;
    s5_hit_r  <= s5_hit_nxt;
    s5_rad_r  <= s5_rad_nxt;
    s5_proj_r <= s4_proj_r;
  end

  assign out_vld      = s5_vld_r;
  assign out_hit      = s5_hit_r;
  assign out_proj     = s5_proj_r;
  assign out_radicand = s5_rad_r;

endmodule

// ===== rtl/rshd_sqrt.sv =====
// ----------------------------------------------------------------------------
// rshd_sqrt: pipelined integer square root
// Restoring digit-by-digit root, one result bit per register stage, with a
// valid bit and a sideband word carried alongside each item.
// ----------------------------------------------------------------------------
module rshd_sqrt #(
  parameter int RAD_W  = 46,
  parameter int SIDE_W = 31
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_vld,
  input  logic [RAD_W-1:0]     in_rad,
  input  logic [SIDE_W-1:0]    in_side,
  output logic                 out_vld,
  output logic [RAD_W/2-1:0]   out_root,
  output logic [SIDE_W-1:0]    out_side
);

  localparam int N    = RAD_W / 2;
  localparam int REMW = N + 3;

  logic              vld_r  [0:N-1];
  logic [REMW-1:0]   rem_r  [0:N-1];
  logic [N-1:0]      root_r [0:N-1];
  logic [RAD_W-1:0]  rad_r  [0:N-1];
  logic [SIDE_W-1:0] side_r [0:N-1];

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic              vld_in;
    logic [REMW-1:0]   rem_in;
    logic [N-1:0]      root_in;
    logic [RAD_W-1:0]  rad_in;
    logic [SIDE_W-1:0] side_in;
    logic [REMW-1:0]   cur, trial, rem_nxt;
    logic [N-1:0]      root_nxt;
    logic              ge;

    // take the item from the ports or the previous stage
    if (i == 0) begin : g_first
      assign vld_in  = in_vld;
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = in_rad;
      assign side_in = in_side;
    end else begin : g_next
      assign vld_in  = vld_r[i-1];
      assign rem_in  = rem_r[i-1];
      assign root_in = root_r[i-1];
      assign rad_in  = rad_r[i-1];
      assign side_in = side_r[i-1];
    end

    // bring down two radicand bits and try the next root bit
    always_comb begin
      cur      = {rem_in[REMW-3:0], rad_in[RAD_W-1 -: 2]};
      trial    = REMW'({root_in, 2'b01});
      ge       = (cur >= trial);
      rem_nxt  = ge ? (cur - trial) : cur;
      root_nxt = {root_in[N-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else begin
        vld_r[i] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      rem_r[i]  <= rem_nxt;
      root_r[i] <= root_nxt;
      rad_r[i]  <= rad_in << 2;
      side_r[i] <= side_in;
    end
  end

  assign out_vld  = vld_r[N-1];
  assign out_root = root_r[N-1];
  assign out_side = side_r[N-1];

endmodule

// ===== rtl/ray_sphere_hit_distance_top.sv =====
// ----------------------------------------------------------------------------
// ray_sphere_hit_distance_top: fixed-point ray / sphere near hit distance
// Geometric intersection test: projection of the origin-to-centre delta on
// the ray, perpendicular square against radius square, root of the chord.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive the ray and sphere on the in_ ports and raise start;
//   the item is taken at a rising edge with start high and busy low. busy
//   stays low, so a new item may be issued at every clock.
//   Result channel: out_valid is high for exactly one cycle per item, with
//   out_hit and out_hit_distance (0 on a miss) valid in that cycle.
//   Pipeline: five geometry stages, one square root stage per root bit and
//   one output stage lie between the accepting edge and the result edge.
//   Throughput: one item per cycle, fixed by the fully pipelined root.
//   Reset: synchronous rst_n clears every valid bit; items in flight are
//   dropped and no result appears until a new item has passed through.
//   Stall: the receiver cannot hold results off; results leave in order.
// ----------------------------------------------------------------------------
module ray_sphere_hit_distance_top
  import rshd_pkg::*;
#(
  parameter int COORD_WIDTH = 24
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_WIDTH-1:0] in_origin_x,
  input  logic signed [COORD_WIDTH-1:0] in_origin_y,
  input  logic signed [COORD_WIDTH-1:0] in_origin_z,
  input  logic signed [DIR_WIDTH-1:0]   in_dir_x,
  input  logic signed [DIR_WIDTH-1:0]   in_dir_y,
  input  logic signed [DIR_WIDTH-1:0]   in_dir_z,
  input  logic signed [COORD_WIDTH-1:0] in_center_x,
  input  logic signed [COORD_WIDTH-1:0] in_center_y,
  input  logic signed [COORD_WIDTH-1:0] in_center_z,
  input  logic [COORD_WIDTH-2:0]        in_sphere_radius,
  output logic                          out_valid,
  output logic                          out_hit,
  output logic signed [DIST_WIDTH-1:0]  out_hit_distance
);

  localparam int RS    = (COORD_WIDTH > REF_WIDTH) ? (COORD_WIDTH - REF_WIDTH) : 0;
  localparam int PROJW = COORD_WIDTH + 6;
  localparam int RRW   = COORD_WIDTH - 1 - RS;
  localparam int DFW   = 2 * RRW;
  localparam int CHW   = COORD_WIDTH - 1;
  localparam int DSW   = PROJW + 1;
  localparam int CMPW  = ((DSW > DIST_WIDTH) ? DSW : DIST_WIDTH) + 1;
  localparam logic signed [CMPW-1:0] D_MAX = CMPW'((64'sd1 <<< (DIST_WIDTH - 1)) - 64'sd1);
  localparam logic signed [CMPW-1:0] D_MIN = -D_MAX - CMPW'(1);

  logic                    in_vld;
  logic                    fr_vld, fr_hit;
  logic signed [PROJW-1:0] fr_proj;
  logic [DFW-1:0]          fr_rad;
  logic                    sq_vld;
  logic [RRW-1:0]          sq_root;
  logic [PROJW:0]          sq_side;
  logic signed [PROJW-1:0] sq_proj;
  logic                    sq_hit;
  logic [CHW-1:0]          chord;
  logic signed [DSW-1:0]   near_dist;
  logic signed [CMPW-1:0]  dist_w, dist_sat;

  logic                        out_valid_r, out_hit_r, out_hit_nxt;
  logic signed [DIST_WIDTH-1:0] out_hit_distance_r, out_hit_distance_nxt;

  // the pipeline never stalls, so every start is taken
  assign busy   = 1'b0;
  assign in_vld = start && !busy;

  rshd_front #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_vld           (in_vld),
    .in_origin_x      (in_origin_x),
    .in_origin_y      (in_origin_y),
    .in_origin_z      (in_origin_z),
    .in_dir_x         (in_dir_x),
    .in_dir_y         (in_dir_y),
    .in_dir_z         (in_dir_z),
    .in_center_x      (in_center_x),
    .in_center_y      (in_center_y),
    .in_center_z      (in_center_z),
    .in_sphere_radius (in_sphere_radius),
    .out_vld          (fr_vld),
    .out_hit          (fr_hit),
    .out_proj         (fr_proj),
    .out_radicand     (fr_rad)
  );

  rshd_sqrt #(
    .RAD_W  (DFW),
    .SIDE_W (PROJW + 1)
  ) u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (fr_vld),
    .in_rad   (fr_rad),
    .in_side  ({fr_hit, fr_proj}),
    .out_vld  (sq_vld),
    .out_root (sq_root),
    .out_side (sq_side)
  );

  // subtract the half-chord and saturate to the distance range
  always_comb begin
    sq_hit    = sq_side[PROJW];
    sq_proj   = $signed(sq_side[PROJW-1:0]);
    chord     = CHW'(sq_root) << RS;
    near_dist = DSW'(sq_proj) - $signed(DSW'(chord));
    dist_w    = CMPW'(near_dist);
    if (dist_w > D_MAX) begin
      dist_sat = D_MAX;
    end else if (dist_w < D_MIN) begin
      dist_sat = D_MIN;
    end else begin
      dist_sat = dist_w;
    end
    out_hit_nxt          = sq_hit;
    out_hit_distance_nxt = sq_hit ? DIST_WIDTH'(dist_sat) : '0;
  end

  // strobe the result for one cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= sq_vld;
    end
  end

  always_ff @(posedge clk) begin
    out_hit_r          <= out_hit_nxt;
    out_hit_distance_r <= out_hit_distance_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_hit          = out_hit_r;
  assign out_hit_distance = out_hit_distance_r;

endmodule

// ===== rtl/rshd_checker.sv =====
// ----------------------------------------------------------------------------
// rshd_checker: port-level checks for the hit distance block
// Watches the top level's ports for strobe timing, reset, miss encoding and busy.
// ----------------------------------------------------------------------------
module rshd_checker
  import rshd_pkg::*;
#(
  parameter int COORD_WIDTH = 24
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          start,
  input logic                          busy,
  input logic signed [COORD_WIDTH-1:0] in_origin_x,
  input logic signed [COORD_WIDTH-1:0] in_origin_y,
  input logic signed [COORD_WIDTH-1:0] in_origin_z,
  input logic signed [DIR_WIDTH-1:0]   in_dir_x,
  input logic signed [DIR_WIDTH-1:0]   in_dir_y,
  input logic signed [DIR_WIDTH-1:0]   in_dir_z,
  input logic signed [COORD_WIDTH-1:0] in_center_x,
  input logic signed [COORD_WIDTH-1:0] in_center_y,
  input logic signed [COORD_WIDTH-1:0] in_center_z,
  input logic [COORD_WIDTH-2:0]        in_sphere_radius,
  input logic                          out_valid,
  input logic                          out_hit,
  input logic signed [DIST_WIDTH-1:0]  out_hit_distance
);

  localparam int RS  = (COORD_WIDTH > REF_WIDTH) ? (COORD_WIDTH - REF_WIDTH) : 0;
  localparam int LAT = 6 + (COORD_WIDTH - 1 - RS);

  // a result strobe only follows an item taken at the input
  a_strobe_from_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LAT))
    else $error("result strobe without an item taken %0d cycles before", LAT);

  // reset leaves no result strobe behind
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result strobe right after reset");

  // a miss carries a zero distance
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_hit) |-> (out_hit_distance == '0))
    else $error("miss reported with a non-zero distance");

  // the block takes an item in every cycle that start is high
  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy)
    else $error("busy raised against a start");

endmodule

bind ray_sphere_hit_distance_top rshd_checker #(
  .COORD_WIDTH (COORD_WIDTH)
) u_rshd_checker (.*);
